/* src/bsd_pkg.sv */
// Shared types, constants and the character classifier of the base64url stream decoder.
package bsd_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_DASH       = 6'd62;
    localparam logic [5:0] SEXTET_UNDERSCORE = 6'd63;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } t_out;

    // A classified character as it travels from the front end to the back end.
    typedef struct packed {
        logic [5:0] sextet;
        logic       is_bad;
        logic       eom;
    } t_item;

    function automatic t_item classify(input logic [7:0] ch, input logic eom);
        t_item      item;
        logic [7:0] diff;
        item.sextet = 6'd0;
        item.is_bad = 1'b0;
        item.eom    = eom;
        diff        = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            diff        = ch - 8'h41;
            item.sextet = diff[5:0];
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            diff        = ch - 8'h61;
            item.sextet = diff[5:0] + SEXTET_LOWER_BASE;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            diff        = ch - 8'h30;
            item.sextet = diff[5:0] + SEXTET_DIGIT_BASE;
        end else if (ch == 8'h2D) begin
            item.sextet = SEXTET_DASH;
        end else if (ch == 8'h5F) begin
            item.sextet = SEXTET_UNDERSCORE;
        end else begin
            item.is_bad = 1'b1;
        end
        return item;
    endfunction

endpackage

/* src/bsd_front.sv */
// Front end: accepts characters and classifies them into sextets for the queue.
module bsd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bsd_pkg::t_in   i_in_data,
    input  logic           i_queue_full,
    output logic           o_push,
    output bsd_pkg::t_item o_push_item
);

    assign o_in_stall  = i_queue_full;
    assign o_push      = i_in_valid && !i_queue_full;
    assign o_push_item = bsd_pkg::classify(i_in_data.in_char, i_in_data.end_of_message);

    // A stalled transaction must keep its payload until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> $stable(i_in_data))
        else $error("input payload changed while stalled");

endmodule

/* src/bsd_queue.sv */
// Short queue of classified characters between the front end and the back end.
module bsd_queue #(
    parameter int DEPTH = bsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsd_pkg::t_item i_push_item,
    input  logic           i_pop,
    output bsd_pkg::t_item o_head,
    output logic           o_full,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    bsd_pkg::t_item r_slots [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_push_item;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue occupancy exceeds its depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a lone push");

endmodule

/* src/bsd_back.sv */
// Back end: tracks the quartet position, assembles bytes and holds the result register.
module bsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsd_pkg::t_item i_head,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bsd_pkg::t_out  o_out_data
);

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    logic [1:0]    r_pos, n_pos;
    logic [5:0]    r_left, n_left;
    logic          r_dropping, n_dropping;
    logic          r_out_valid;
    bsd_pkg::t_out r_out;
    logic          take;
    logic          res_valid;
    bsd_pkg::t_out res;

    assign take  = !i_empty && (!r_out_valid || !i_out_stall);
    assign o_pop = take;

    always_comb begin
        n_pos      = r_pos;
        n_left     = r_left;
        n_dropping = r_dropping;
        res_valid  = 1'b0;
        res        = '0;
        if (take) begin
            if (r_dropping) begin
                if (i_head.eom) begin
                    n_dropping = 1'b0;
                end
            end else if (i_head.is_bad) begin
                res_valid  = 1'b1;
                res.last   = 1'b1;
                res.status = bsd_pkg::STATUS_BAD_CHAR;
                n_pos      = POS_FIRST;
                n_left     = '0;
                n_dropping = !i_head.eom;
            end else begin
                unique case (r_pos)
                    POS_FIRST: begin
                        if (i_head.eom) begin
                            res_valid  = 1'b1;
                            res.last   = 1'b1;
                            res.status = bsd_pkg::STATUS_BAD_LEN;
                        end else begin
                            n_left = i_head.sextet;
                            n_pos  = POS_SECOND;
                        end
                    end
                    POS_SECOND: begin
                        res_valid    = 1'b1;
                        res.out_byte = {r_left, i_head.sextet[5:4]};
                        n_left       = {2'b00, i_head.sextet[3:0]};
                        n_pos        = POS_THIRD;
                    end
                    POS_THIRD: begin
                        res_valid    = 1'b1;
                        res.out_byte = {r_left[3:0], i_head.sextet[5:2]};
                        n_left       = {4'b0000, i_head.sextet[1:0]};
                        n_pos        = POS_FOURTH;
                    end
                    POS_FOURTH: begin
                        res_valid    = 1'b1;
                        res.out_byte = {r_left[1:0], i_head.sextet};
                        n_left       = '0;
                        n_pos        = POS_FIRST;
                    end
                    default: begin
                        n_pos = POS_FIRST;
                    end
                endcase
                res.last = i_head.eom;
                // The end flag returns the decoder to its idle state whatever the position.
                if (i_head.eom) begin
                    n_pos  = POS_FIRST;
                    n_left = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_FIRST;
            r_left      <= '0;
            r_dropping  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_left     <= n_left;
            r_dropping <= n_dropping;
            if (take && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status != bsd_pkg::STATUS_OK
            |-> r_out.out_byte == 8'd0 && r_out.last)
        else $error("error result without zero byte and last flag");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> r_pos == POS_FIRST && r_left == 6'd0)
        else $error("position or leftover bits kept while dropping");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_THIRD |-> r_left[5:4] == 2'b00) and
        (r_pos == POS_FOURTH |-> r_left[5:2] == 4'b0000))
        else $error("leftover bits wider than the quartet position allows");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result lost or overwritten");

endmodule

/* src/base64url_stream_decoder.sv */
// Top level of the unpadded base64url stream decoder.
// One character is accepted per cycle while not stalled, and at most one byte or error result
// leaves per cycle; each character passes through a queue slot before the back end registers
// its result. The back end's position, leftover-bit and drop registers update per character,
// so the sustained rate is one character per clock while the output does not stall. The
// QUEUE_DEPTH-entry queue between the classifier and the byte assembler absorbs output stalls;
// the input stalls only once that queue is full. Errors end with a result whose last flag is
// set, and the remainder of a failed message up to its end flag is consumed without results.
module base64url_stream_decoder #(
    parameter int QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bsd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bsd_pkg::t_out o_out_data
);

    logic           push;
    bsd_pkg::t_item push_item;
    logic           pop;
    bsd_pkg::t_item head;
    logic           queue_full;
    logic           queue_empty;

    bsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_item  (push_item)
    );

    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_full      (queue_full),
        .o_empty     (queue_empty)
    );

    bsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (queue_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
